>>> hw/rtl/rpn_pkg.sv
// ============================================================================
// rpn_pkg : shared definitions for the RPN stack calculator
// Widths, request codes, controller states and the command/status bundles.
// ============================================================================
package rpn_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    localparam logic [2:0] REQ_PUSH  = 3'd0;
    localparam logic [2:0] REQ_ADD   = 3'd1;
    localparam logic [2:0] REQ_SUB   = 3'd2;
    localparam logic [2:0] REQ_MUL   = 3'd3;
    localparam logic [2:0] REQ_DIV   = 3'd4;
    localparam logic [2:0] REQ_FINAL = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_POP_RHS,
        ST_POP_LHS,
        ST_EXEC,
        ST_DIV,
        ST_DIV_FIX,
        ST_POP_FINAL,
        ST_FINAL_GET,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic pop;
        logic latch_rhs;
        logic exec;
        logic div_start;
        logic div_fix;
        logic push;
        logic latch_final;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] req;
        logic       rhs_zero;
        logic       div_done;
    } dp_status_t;

endpackage

>>> hw/rtl/rpn_divider.sv
// ============================================================================
// rpn_divider : unsigned restoring divider
// One quotient bit per cycle; done pulses once the last bit is in.
// ============================================================================
module rpn_divider
    import rpn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic [DATA_W-1:0] quotient,
    output logic              done
);

    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W-1:0]    rem_next;
    logic [DATA_W-1:0]    quo_reg;
    logic [DATA_W-1:0]    quo_next;
    logic [DATA_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      trial;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        if (!trial[DATA_W])
        begin
            rem_next = trial[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DATA_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

>>> hw/rtl/rpn_datapath.sv
// ============================================================================
// rpn_datapath : stack store, operand registers and arithmetic
// Holds the stack memory and count, the ALU, the divider and result flags.
// ============================================================================
module rpn_datapath
    import rpn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    input  logic [2:0]        req_type,
    input  logic [DATA_W-1:0] value,
    output dp_status_t        status,
    output logic [DATA_W-1:0] res,
    output logic [CNT_W-1:0]  depth,
    output logic              flag_under,
    output logic              flag_over,
    output logic              flag_dz
);

    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_dec;
    logic [2:0]        req_reg;
    logic [DATA_W-1:0] res_reg;
    logic [DATA_W-1:0] rhs_reg;
    logic              empty_reg;
    logic              under_reg;
    logic              over_reg;
    logic              dz_reg;
    logic              neg_reg;
    logic              full;
    logic              stack_empty;
    logic [DATA_W-1:0] operand;
    logic [DATA_W-1:0] product;
    logic [DATA_W-1:0] mag_lhs;
    logic [DATA_W-1:0] mag_rhs;
    logic [DATA_W-1:0] quotient;
    logic              div_done;

    assign count_dec   = count_reg - 1'b1;
    assign full        = (count_reg == CNT_W'(STACK_DEPTH));
    assign stack_empty = (count_reg == '0);
    assign operand     = empty_reg ? '1 : rd_data_reg;
    assign product     = operand * rhs_reg;
    assign mag_lhs     = operand[DATA_W-1] ? (~operand + 1'b1) : operand;
    assign mag_rhs     = rhs_reg[DATA_W-1] ? (~rhs_reg + 1'b1) : rhs_reg;

    rpn_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (mag_lhs),
        .divisor  (mag_rhs),
        .quotient (quotient),
        .done     (div_done)
    );

    // stack memory: one write port, one registered read port at the top
    always_ff @(posedge clk)
    begin
        if (cmd.push && !full)
        begin
            mem[count_reg[ADDR_W-1:0]] <= res_reg;
        end
        rd_data_reg <= mem[count_dec[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            req_reg   <= REQ_PUSH;
            empty_reg <= 1'b0;
            under_reg <= 1'b0;
            over_reg  <= 1'b0;
            dz_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                req_reg   <= req_type;
                under_reg <= 1'b0;
                over_reg  <= 1'b0;
                dz_reg    <= 1'b0;
            end
            if (cmd.pop)
            begin
                empty_reg <= stack_empty;
                if (stack_empty)
                begin
                    under_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_dec;
                end
            end
            if (cmd.exec && (req_reg == REQ_DIV) && (rhs_reg == '0))
            begin
                dz_reg <= 1'b1;
            end
            if (cmd.push)
            begin
                if (full)
                begin
                    over_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_reg <= (req_type == REQ_PUSH) ? value : '0;
        end
        else if (cmd.exec)
        begin
            case (req_reg)
                REQ_ADD: res_reg <= operand + rhs_reg;
                REQ_SUB: res_reg <= operand - rhs_reg;
                REQ_MUL: res_reg <= product;
                REQ_DIV: res_reg <= '0;
                default: res_reg <= res_reg;
            endcase
        end
        else if (cmd.div_fix)
        begin
            res_reg <= neg_reg ? (~quotient + 1'b1) : quotient;
        end
        else if (cmd.latch_final)
        begin
            res_reg <= operand;
        end

        if (cmd.latch_rhs)
        begin
            rhs_reg <= operand;
        end
        if (cmd.div_start)
        begin
            neg_reg <= operand[DATA_W-1] ^ rhs_reg[DATA_W-1];
        end
    end

    assign status.req      = req_reg;
    assign status.rhs_zero = (rhs_reg == '0);
    assign status.div_done = div_done;

    assign res        = res_reg;
    assign depth      = count_reg;
    assign flag_under = under_reg;
    assign flag_over  = over_reg;
    assign flag_dz    = dz_reg;

endmodule

>>> hw/rtl/rpn_ctrl.sv
// ============================================================================
// rpn_ctrl : request sequencer
// Steps each request through the pop, execute, divide, push or final-read phases it needs.
// ============================================================================
module rpn_ctrl
    import rpn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] req_type,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy,
    output logic       done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (req_type)
                        REQ_PUSH:                          state_next = ST_PUSH;
                        REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV: state_next = ST_POP_RHS;
                        REQ_FINAL:                         state_next = ST_POP_FINAL;
                        default:                           state_next = ST_FINISH;
                    endcase
                end
            end
            ST_POP_RHS:
            begin
                cmd.pop    = 1'b1;
                state_next = ST_POP_LHS;
            end
            ST_POP_LHS:
            begin
                cmd.pop       = 1'b1;
                cmd.latch_rhs = 1'b1;
                state_next    = ST_EXEC;
            end
            ST_EXEC:
            begin
                if ((status.req == REQ_DIV) && !status.rhs_zero)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_PUSH;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_DIV_FIX;
                end
            end
            ST_DIV_FIX:
            begin
                cmd.div_fix = 1'b1;
                state_next  = ST_PUSH;
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_POP_FINAL:
            begin
                cmd.pop    = 1'b1;
                state_next = ST_FINAL_GET;
            end
            ST_FINAL_GET:
            begin
                cmd.latch_final = 1'b1;
                state_next      = ST_FINISH;
            end
            ST_FINISH:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/rpn_stack_calculator.sv
// ============================================================================
// rpn_stack_calculator : reverse-Polish integer stack calculator
// Top level joining the request sequencer and the stack datapath.
// ============================================================================
// A request is taken when start is high and busy is low; its single result
// appears with done high for one cycle and must be captured then, as the block
// cannot be stalled. A new request is not taken until the last one is done.
// Divides with a nonzero divisor run on the restoring divider, one quotient bit
// per cycle, and every pop reads through the stack memory's registered port.
module rpn_stack_calculator
    import rpn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               req_type,
    input  logic signed [DATA_W-1:0] value,
    output logic                     done,
    output logic signed [DATA_W-1:0] result_value,
    output logic [CNT_W-1:0]         stack_depth,
    output logic                     underflow,
    output logic                     overflow,
    output logic                     divide_by_zero
);

    ctrl_cmd_t         cmd;
    dp_status_t        status;
    logic [DATA_W-1:0] res;

    rpn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    rpn_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req_type   (req_type),
        .value      ($unsigned(value)),
        .status     (status),
        .res        (res),
        .depth      (stack_depth),
        .flag_under (underflow),
        .flag_over  (overflow),
        .flag_dz    (divide_by_zero)
    );

    assign result_value = $signed(res);

`ifndef SYNTHESIS
    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a busy request");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (stack_depth <= CNT_W'(STACK_DEPTH)))
        else $error("stack depth beyond capacity");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(overflow && underflow))
        else $error("overflow and underflow in one request");
`endif

endmodule
